// ===== hw/rtl/scsu_pkg.sv =====
// ----------------------------------------------------------------------------
// scsu_pkg
// Shared types and constants for the shadow call stack with unwind on return.
// ----------------------------------------------------------------------------
package scsu_pkg;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam int unsigned ADDR_FIELD_W = 64;
    localparam int unsigned CNT_FIELD_W  = 9;
    localparam int unsigned IN_TDATA_W   = 64;
    localparam int unsigned OUT_TDATA_W  = 88;

    localparam int unsigned OUT_DEPTH_LSB   = 0;
    localparam int unsigned OUT_REMOVED_LSB = 9;
    localparam int unsigned OUT_MATCH_BIT   = 18;
    localparam int unsigned OUT_LOST_BIT    = 19;
    localparam int unsigned OUT_TOP_LSB     = 20;
    localparam int unsigned OUT_USED_W      = 84;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_TOP,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic push;
        logic pop_start;
        logic pop_step;
        logic top_load;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_one;
        logic hit;
    } ctl_sts_t;

endpackage

// ===== hw/rtl/shadow_call_stack_unwind_top.sv =====
// ----------------------------------------------------------------------------
// shadow_call_stack_unwind_top
// Shadow stack of return addresses in a ring; pop unwinds to a matching entry.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                   tuser
//  s_*      in   ret_addr[63:0]                          req_type
//  m_*      out  depth_after, removed_count, match_found, -
//                oldest_lost, top_addr (low bit up)
//
//  push or pop on an empty stack: ST_IDLE accepts, then ST_FIN waits for a free output
//  pop: ST_POP removes one entry per step, then ST_TOP on a match, then ST_FIN
//  the walk reads one entry per cycle from the single read port of the ring
//  reset leaves the stack empty; ring contents are not cleared
//  a result waits in the output register while the next request is worked
// ----------------------------------------------------------------------------
module shadow_call_stack_unwind_top
#(
    parameter int unsigned DEPTH     = 256,
    parameter int unsigned ADDR_BITS = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [scsu_pkg::IN_TDATA_W-1:0]     s_tdata,   // ret_addr
    input  logic                                s_tuser,   // req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // depth_after, removed_count, match_found, oldest_lost, top_addr, zero pad
    output logic [scsu_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    scsu_pkg::ctl_cmd_t cmd;
    scsu_pkg::ctl_sts_t sts;

    scsu_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_req_type (s_tuser),
        .in_ready    (s_tready),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .sts         (sts),
        .cmd         (cmd)
    );

    scsu_datapath
    #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_addr  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_tdata)
    );

endmodule

// ===== hw/rtl/scsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// scsu_ctrl
// Sequencer for push, pop walk and result hand-off to the output register.
// ----------------------------------------------------------------------------
module scsu_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_req_type,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  scsu_pkg::ctl_sts_t  sts,
    output scsu_pkg::ctl_cmd_t  cmd
);

    scsu_pkg::state_t state_reg;
    scsu_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;
    logic             accept;

    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && (state_reg == scsu_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scsu_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_req_type == scsu_pkg::REQ_PUSH || sts.cnt_zero)
                        state_next = scsu_pkg::ST_FIN;
                    else
                        state_next = scsu_pkg::ST_POP;
                end
            end
            scsu_pkg::ST_POP:
            begin
                if (sts.hit)
                    state_next = scsu_pkg::ST_TOP;
                else if (sts.cnt_one)
                    state_next = scsu_pkg::ST_FIN;
            end
            scsu_pkg::ST_TOP:
            begin
                state_next = scsu_pkg::ST_FIN;
            end
            scsu_pkg::ST_FIN:
            begin
                if (out_free)
                    state_next = scsu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = scsu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            scsu_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.push      = accept && (in_req_type == scsu_pkg::REQ_PUSH);
                cmd.pop_start = accept && (in_req_type == scsu_pkg::REQ_POP);
            end
            scsu_pkg::ST_POP:
            begin
                cmd.pop_step = 1'b1;
            end
            scsu_pkg::ST_TOP:
            begin
                cmd.top_load = 1'b1;
            end
            scsu_pkg::ST_FIN:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scsu_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/scsu_datapath.sv =====
// ----------------------------------------------------------------------------
// scsu_datapath
// Entry ring memory, top pointer, entry count and result registers.
// ----------------------------------------------------------------------------
module scsu_datapath
#(
    parameter int unsigned DEPTH     = 256,
    parameter int unsigned ADDR_BITS = 64
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [scsu_pkg::ADDR_FIELD_W-1:0]     in_addr,
    input  scsu_pkg::ctl_cmd_t                    cmd,
    output scsu_pkg::ctl_sts_t                    sts,
    output logic [scsu_pkg::OUT_TDATA_W-1:0]      out_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [ADDR_BITS-1:0] mem [DEPTH];

    logic [PTR_W-1:0]     ptr_reg;
    logic [PTR_W-1:0]     ptr_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [PTR_W-1:0]     ptr_up;
    logic [PTR_W-1:0]     ptr_dn1;
    logic [PTR_W-1:0]     ptr_dn2;
    logic [PTR_W-1:0]     rd_addr;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_data_reg;
    logic [ADDR_BITS-1:0] addr_in;
    logic [ADDR_BITS-1:0] key_reg;
    logic [CNT_W-1:0]     removed_reg;
    logic                 found_reg;
    logic                 lost_reg;
    logic [ADDR_BITS-1:0] top_reg;
    logic                 full;
    logic [31:0]          cnt_ext;
    logic [31:0]          removed_ext;
    logic [scsu_pkg::OUT_USED_W-1:0] res;
    logic [scsu_pkg::OUT_USED_W-1:0] out_reg;

    assign addr_in = in_addr[ADDR_BITS-1:0];
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign ptr_up  = (ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign ptr_dn1 = (ptr_reg == '0) ? PTR_W'(DEPTH - 1) : ptr_reg - 1'b1;
    assign ptr_dn2 = (ptr_dn1 == '0) ? PTR_W'(DEPTH - 1) : ptr_dn1 - 1'b1;
    assign rd_en   = cmd.pop_start || cmd.pop_step;
    assign rd_addr = cmd.pop_start ? ptr_dn1 : ptr_dn2;

    assign sts.cnt_zero = (cnt_reg == '0);
    assign sts.cnt_one  = (cnt_reg == CNT_W'(1));
    assign sts.hit      = (rd_data_reg == key_reg);

    always_comb
    begin
        ptr_next = ptr_reg;
        cnt_next = cnt_reg;
        if (cmd.push)
        begin
            ptr_next = ptr_up;
            if (!full)
                cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.pop_step)
        begin
            ptr_next = ptr_dn1;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    // ring store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[ptr_reg] <= addr_in;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            removed_reg <= '0;
            found_reg   <= 1'b0;
            lost_reg    <= full;
            top_reg     <= addr_in;
        end
        else if (cmd.pop_start)
        begin
            key_reg     <= addr_in;
            removed_reg <= '0;
            found_reg   <= 1'b0;
            lost_reg    <= 1'b0;
            if (cnt_reg == '0)
                top_reg <= '0;
        end
        else if (cmd.pop_step)
        begin
            removed_reg <= removed_reg + 1'b1;
            if (sts.hit)
                found_reg <= 1'b1;
            else if (sts.cnt_one)
                top_reg <= '0;
        end
        else if (cmd.top_load)
        begin
            top_reg <= (cnt_reg == '0) ? '0 : rd_data_reg;
        end
    end

    assign cnt_ext     = 32'(cnt_reg);
    assign removed_ext = 32'(removed_reg);

    always_comb
    begin
        res = '0;
        res[scsu_pkg::OUT_DEPTH_LSB +: scsu_pkg::CNT_FIELD_W]   = cnt_ext[8:0];
        res[scsu_pkg::OUT_REMOVED_LSB +: scsu_pkg::CNT_FIELD_W] = removed_ext[8:0];
        res[scsu_pkg::OUT_MATCH_BIT]                           = found_reg;
        res[scsu_pkg::OUT_LOST_BIT]                            = lost_reg;
        res[scsu_pkg::OUT_TOP_LSB +: scsu_pkg::ADDR_FIELD_W] =
            scsu_pkg::ADDR_FIELD_W'(top_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_reg <= res;
    end

    assign out_data = scsu_pkg::OUT_TDATA_W'(out_reg);

endmodule

// ===== hw/rtl/scsu_checker.sv =====
// ----------------------------------------------------------------------------
// scsu_checker
// Port-level checks on the result stream of the shadow call stack.
// ----------------------------------------------------------------------------
module scsu_checker
#(
    parameter int unsigned DEPTH = 256
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [scsu_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    logic [8:0]  depth_f;
    logic [8:0]  removed_f;
    logic        match_f;
    logic        lost_f;
    logic [63:0] top_f;

    assign depth_f   = m_tdata[8:0];
    assign removed_f = m_tdata[17:9];
    assign match_f   = m_tdata[18];
    assign lost_f    = m_tdata[19];
    assign top_f     = m_tdata[83:20];

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(match_f && lost_f))
        else $error("match and overwrite flags both set");

    a_match_removed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && match_f && (DEPTH < 512) |-> removed_f != 9'd0)
        else $error("match reported with nothing removed");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (DEPTH < 512) && depth_f == 9'd0 |-> top_f == 64'd0)
        else $error("empty stack with nonzero top");

endmodule

bind shadow_call_stack_unwind_top scsu_checker
#(
    .DEPTH (DEPTH)
)
u_scsu_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shadow call stack with unwind on return. Push
// and pop requests go in from a queue through a clocked driver, a local
// ring model predicts each result and a clocked monitor compares every field.
// Directed corner cases come first. A pressure phase queues pushes past
// full while the output is held off. Random phases under varied idling and stalls follow.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned STACK_DEPTH = 256;
    localparam int unsigned HOLD_CYCLES = 500;

    typedef struct packed {
        logic        kind;
        logic [63:0] addr;
    } stack_req_t;

    typedef struct packed {
        logic [8:0]  depth;
        logic [8:0]  removed;
        logic        hit;
        logic        lost;
        logic [63:0] top_addr;
    } stack_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [scsu_pkg::IN_TDATA_W-1:0]   s_tdata = '0;
    logic                              s_tuser = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [scsu_pkg::OUT_TDATA_W-1:0]  m_tdata;

    stack_req_t    pending_reqs[$];
    stack_result_t expected_results[$];
    logic [63:0]   recent_pushes[$];

    // ring model
    logic [63:0] ring_copy [STACK_DEPTH];
    logic [7:0]  ring_top_ptr = '0;
    int unsigned ring_held = 0;

    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    logic        hold_on = 1'b0;

    int unsigned errors = 0;
    int unsigned push_cnt = 0;
    int unsigned pop_cnt = 0;
    int unsigned result_cnt = 0;
    int unsigned hit_cnt = 0;
    int unsigned lost_cnt = 0;
    int unsigned deepest = 0;

    shadow_call_stack_unwind_top
    #(
        .DEPTH     (STACK_DEPTH),
        .ADDR_BITS (64)
    )
    dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        foreach (ring_copy[i])
        begin
            ring_copy[i] = '0;
        end
    end

    task automatic predict_request(input logic kind, input logic [63:0] addr);
        stack_result_t r;
        logic [7:0]    below;
        r = '0;
        if (kind == scsu_pkg::REQ_PUSH)
        begin
            ring_copy[ring_top_ptr] = addr;
            ring_top_ptr = ring_top_ptr + 8'd1;
            if (ring_held == STACK_DEPTH)
            begin
                r.lost = 1'b1;
            end
            else
            begin
                ring_held++;
            end
        end
        else
        begin
            while (ring_held > 0 && !r.hit)
            begin
                ring_top_ptr = ring_top_ptr - 8'd1;
                ring_held--;
                r.removed = r.removed + 9'd1;
                if (ring_copy[ring_top_ptr] == addr)
                begin
                    r.hit = 1'b1;
                end
            end
        end
        r.depth = ring_held[8:0];
        below = ring_top_ptr - 8'd1;
        r.top_addr = (ring_held == 0) ? 64'd0 : ring_copy[below];
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s mismatch: expected %h, got %h", name, exp_val, got_val);
            errors++;
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        stack_req_t next_req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_request(s_tuser, s_tdata);
                if (s_tuser == scsu_pkg::REQ_PUSH)
                begin
                    push_cnt++;
                end
                else
                begin
                    pop_cnt++;
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    next_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.addr;
                    s_tuser  <= next_req.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        stack_result_t exp_r;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_cnt++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("depth_after", 64'(exp_r.depth),
                        64'(m_tdata[scsu_pkg::OUT_DEPTH_LSB +: scsu_pkg::CNT_FIELD_W]));
                    check_field("removed_count", 64'(exp_r.removed),
                        64'(m_tdata[scsu_pkg::OUT_REMOVED_LSB +: scsu_pkg::CNT_FIELD_W]));
                    check_field("match_found", 64'(exp_r.hit),
                        64'(m_tdata[scsu_pkg::OUT_MATCH_BIT]));
                    check_field("oldest_lost", 64'(exp_r.lost),
                        64'(m_tdata[scsu_pkg::OUT_LOST_BIT]));
                    check_field("top_addr", exp_r.top_addr,
                        m_tdata[scsu_pkg::OUT_TOP_LSB +: scsu_pkg::ADDR_FIELD_W]);
                    if (exp_r.hit)
                    begin
                        hit_cnt++;
                    end
                    if (exp_r.lost)
                    begin
                        lost_cnt++;
                    end
                    if (exp_r.depth > deepest)
                    begin
                        deepest = exp_r.depth;
                    end
                end
            end
            m_tready <= !hold_on && ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [63:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    task automatic add_req(input logic kind, input logic [63:0] addr);
        stack_req_t r;
        r.kind = kind;
        r.addr = addr;
        pending_reqs.push_back(r);
        if (kind == scsu_pkg::REQ_PUSH)
        begin
            recent_pushes.push_back(addr);
            if (recent_pushes.size() > 32)
            begin
                void'(recent_pushes.pop_front());
            end
        end
    endtask

    task automatic add_random(input int unsigned n);
        int unsigned pick;
        repeat (n)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 58)
            begin
                add_req(scsu_pkg::REQ_PUSH,
                        (pick < 30) ? 64'($urandom_range(7)) : rand_addr());
            end
            else if (pick < 60 && recent_pushes.size() != 0)
            begin
                add_req(scsu_pkg::REQ_POP,
                        recent_pushes[$urandom_range(recent_pushes.size() - 1)]);
            end
            else if (pick < 75)
            begin
                add_req(scsu_pkg::REQ_POP, 64'($urandom_range(7)));
            end
            else
            begin
                add_req(scsu_pkg::REQ_POP, rand_addr());
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic run_phase(input int unsigned idle, input int unsigned stall,
                             input int unsigned n);
        @(negedge clk);
        idle_pct  = idle;
        stall_pct = stall;
        add_random(n);
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corner cases
        add_req(scsu_pkg::REQ_POP, 64'd0);
        add_req(scsu_pkg::REQ_PUSH, 64'd0);
        add_req(scsu_pkg::REQ_PUSH, '1);
        add_req(scsu_pkg::REQ_PUSH, 64'h5555_5555_5555_5555);
        add_req(scsu_pkg::REQ_PUSH, 64'haaaa_aaaa_aaaa_aaaa);
        add_req(scsu_pkg::REQ_POP, '1);
        add_req(scsu_pkg::REQ_POP, 64'd0);
        add_req(scsu_pkg::REQ_POP, 64'h1234);
        add_req(scsu_pkg::REQ_PUSH, 64'd1);
        add_req(scsu_pkg::REQ_PUSH, 64'd2);
        add_req(scsu_pkg::REQ_PUSH, 64'd3);
        add_req(scsu_pkg::REQ_POP, 64'hdead_beef);
        add_req(scsu_pkg::REQ_PUSH, 64'd7);
        add_req(scsu_pkg::REQ_PUSH, 64'd7);
        add_req(scsu_pkg::REQ_POP, 64'd7);
        add_req(scsu_pkg::REQ_POP, 64'd7);
        add_req(scsu_pkg::REQ_POP, 64'd7);
        add_req(scsu_pkg::REQ_PUSH, 64'h8000_0000_0000_0000);
        add_req(scsu_pkg::REQ_POP, 64'h8000_0000_0000_0000);
        wait_drained();

        // queue pushes past full while the output is held off
        hold_on = 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                @(negedge clk);
                hold_on = 1'b0;
            end
        join_none
        repeat (STACK_DEPTH + 8)
        begin
            add_req(scsu_pkg::REQ_PUSH, rand_addr());
        end
        add_req(scsu_pkg::REQ_POP,
                recent_pushes[$urandom_range(recent_pushes.size() - 1)]);
        add_req(scsu_pkg::REQ_POP, rand_addr());
        wait_drained();

        run_phase(0, 0, 45);
        run_phase(86, 0, 45);
        run_phase(0, 86, 45);
        run_phase(32, 32, 45);

        repeat (16) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        $display("tb_top: %0d pushes, %0d pops, %0d results checked",
                 push_cnt, pop_cnt, result_cnt);
        $display("tb_top: %0d pops matched, %0d overwrites, deepest stack %0d",
                 hit_cnt, lost_cnt, deepest);
        if (errors == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
